// ----- design/dsg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsg_pkg
// Shared types and constants of the strike density grid.
// ----------------------------------------------------------------------------
package dsg_pkg;

    localparam int MAX_DIM_DEFAULT    = 128;
    localparam int MAX_RADIUS_DEFAULT = 15;
    localparam int COUNT_BITS_DEFAULT = 16;

    localparam int COORD_W = 7;
    localparam int AMP_W   = 16;
    localparam int OUT_W   = 16;
    localparam int GRID_W  = 8;
    localparam int RADIUS_W = 4;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    localparam logic [1:0] FUNC_STAMP      = 2'd0;
    localparam logic [1:0] FUNC_READ       = 2'd1;
    localparam logic [1:0] FUNC_READ_CLEAR = 2'd2;

    localparam logic [1:0] POL_POSITIVE = 2'd1;
    localparam logic [1:0] POL_NEGATIVE = 2'd2;

    localparam logic [2:0] REG_RADIUS   = 3'd0;
    localparam logic [2:0] REG_WIDTH    = 3'd1;
    localparam logic [2:0] REG_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_POLARITY = 3'd3;
    localparam logic [2:0] REG_MIN_MAG  = 3'd4;
    localparam logic [2:0] REG_MAX_MAG  = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STAMP,
        ST_DRAIN,
        ST_READ,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic hit;
        logic last;
    } walk_status_t;

endpackage

// ----- design/dsg_walk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsg_walk
// Offset sequencer: walks the square around a strike one offset a cycle,
// keeps dx^2 and dy^2 by running sums and flags cells inside radius and grid.
// ----------------------------------------------------------------------------
module dsg_walk #(
    parameter int MAX_DIM    = dsg_pkg::MAX_DIM_DEFAULT,
    parameter int MAX_RADIUS = dsg_pkg::MAX_RADIUS_DEFAULT,
    localparam int RAD_BITS  = $clog2(MAX_RADIUS + 1),
    localparam int DIM_BITS  = $clog2(MAX_DIM),
    localparam int AW        = 2 * DIM_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [dsg_pkg::COORD_W-1:0]       col,
    input  logic [dsg_pkg::COORD_W-1:0]       row,
    input  logic [RAD_BITS-1:0]               radius,
    input  logic [dsg_pkg::GRID_W-1:0]        width,
    input  logic [dsg_pkg::GRID_W-1:0]        height,
    output dsg_pkg::walk_status_t             status,
    output logic [AW-1:0]                     addr
);

    localparam int SQ_W = 2 * RAD_BITS + 1;
    localparam int CW   = ((RAD_BITS > dsg_pkg::COORD_W) ? RAD_BITS : dsg_pkg::COORD_W) + 2;

    logic                               busy_reg;
    logic signed [RAD_BITS:0]           dx_reg, dy_reg;
    logic [SQ_W-1:0]                    dx2_reg, dy2_reg, rad2_reg;
    logic [RAD_BITS-1:0]                rad_reg;
    logic [dsg_pkg::COORD_W-1:0]        col_reg, row_reg;
    logic [dsg_pkg::GRID_W-1:0]         w_reg, h_reg;

    logic signed [RAD_BITS:0]           rad_s;
    logic signed [RAD_BITS+1:0]         dx_step, dy_step;
    logic [SQ_W-1:0]                    start_sq;
    logic [SQ_W-1:0]                    dist2;
    logic [CW-1:0]                      x, y;
    logic                               row_end, last, in_circle, in_grid;

    assign rad_s    = $signed({1'b0, rad_reg});
    assign dx_step  = $signed({dx_reg, 1'b1});
    assign dy_step  = $signed({dy_reg, 1'b1});
    assign start_sq = SQ_W'(radius) * SQ_W'(radius);
    assign dist2    = dx2_reg + dy2_reg;
    assign row_end  = (dx_reg == rad_s);
    assign last     = row_end && (dy_reg == rad_s);

    assign x = CW'(col_reg) + CW'(dx_reg);
    assign y = CW'(row_reg) + CW'(dy_reg);

    assign in_circle = (dist2 <= rad2_reg);
    assign in_grid   = !x[CW-1] && !y[CW-1] && (x < CW'(w_reg)) && (y < CW'(h_reg));

    assign status.hit  = busy_reg && in_circle && in_grid;
    assign status.last = busy_reg && last;
    assign addr        = {DIM_BITS'(y), DIM_BITS'(x)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && last) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radius;
            rad2_reg <= start_sq;
            dx_reg   <= -$signed({1'b0, radius});
            dy_reg   <= -$signed({1'b0, radius});
            dx2_reg  <= start_sq;
            dy2_reg  <= start_sq;
            col_reg  <= col;
            row_reg  <= row;
            w_reg    <= width;
            h_reg    <= height;
        end else if (busy_reg) begin
            if (row_end) begin
                dx_reg  <= -rad_s;
                dx2_reg <= rad2_reg;
                dy_reg  <= dy_reg + 1'b1;
                dy2_reg <= dy2_reg + SQ_W'(dy_step);
            end else begin
                dx_reg  <= dx_reg + 1'b1;
                dx2_reg <= dx2_reg + SQ_W'(dx_step);
            end
        end
    end

endmodule

// ----- design/disk_stamp_strike_density_grid_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_stamp_strike_density_grid_unit
// Grid of saturating strike counts, stamped over a disk and read per cell.
// ----------------------------------------------------------------------------
// Input beats (s_valid/s_ready) carry func, col, row and amplitude. A stamp
// on the active grid that passes the polarity and magnitude filters adds
// one to every cell of the disk around (col, row), clipped to the active
// grid; it gives no result. A read or read-and-clear gives one beat on
// m_valid/m_ready with the count. A stamp walks the (2r+1)^2 offsets one
// a cycle through the offset sequencer and the single read-modify-write
// port pair of the cell memory, then drains its last update before the
// input is ready again. A rejected stamp or a spare func code is dropped.
// A read passes the read and response states and shows its count in the
// same cycle that it frees the input. After reset the cell memory is swept
// to zero one cell a cycle, all 2^(2*clog2(MAX_DIM)) cells (16384 at the
// default size); s_ready is low meanwhile, configuration writes are taken
// as ever. The result sits in an output register: a stalled receiver
// holds only a later read, which waits until the pending count is taken.
// ----------------------------------------------------------------------------
module disk_stamp_strike_density_grid_unit #(
    parameter int MAX_DIM    = dsg_pkg::MAX_DIM_DEFAULT,
    parameter int MAX_RADIUS = dsg_pkg::MAX_RADIUS_DEFAULT,
    parameter int COUNT_BITS = dsg_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dsg_pkg::APB_AW-1:0]          paddr,
    input  logic [dsg_pkg::APB_DW-1:0]          pwdata,
    output logic [dsg_pkg::APB_DW-1:0]          prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_func,
    input  logic [dsg_pkg::COORD_W-1:0]         s_col,
    input  logic [dsg_pkg::COORD_W-1:0]         s_row,
    input  logic signed [dsg_pkg::AMP_W-1:0]    s_amplitude,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dsg_pkg::OUT_W-1:0]           m_count
);

    localparam int RAD_BITS = $clog2(MAX_RADIUS + 1);
    localparam int DIM_BITS = $clog2(MAX_DIM);
    localparam int AW       = 2 * DIM_BITS;
    localparam int DEPTH    = 1 << AW;
    localparam int DIM_CAP  = (MAX_DIM > 255) ? 255 : MAX_DIM;
    localparam int GW       = dsg_pkg::GRID_W;

    dsg_pkg::state_t                    state_reg, state_next;
    logic [AW-1:0]                      clr_cnt_reg;

    logic [dsg_pkg::RADIUS_W-1:0]       radius_reg;
    logic [GW-1:0]                      width_reg, height_reg;
    logic [1:0]                         polarity_reg;
    logic [dsg_pkg::AMP_W-1:0]          min_mag_reg, max_mag_reg;

    logic [1:0]                         func_reg;
    logic [dsg_pkg::COORD_W-1:0]        col_reg, row_reg;
    logic                               on_grid_reg;
    logic                               pend_valid_reg;
    logic [AW-1:0]                      pend_addr_reg;
    logic                               m_valid_reg;
    logic [dsg_pkg::OUT_W-1:0]          m_count_reg;

    logic [COUNT_BITS-1:0]              cell_mem [DEPTH];
    logic [COUNT_BITS-1:0]              rdata_reg;
    logic                               mem_we;
    logic [AW-1:0]                      mem_waddr, mem_raddr;
    logic [COUNT_BITS-1:0]              mem_wdata, rdata_inc;

    logic [GW-1:0]                      w_act, h_act;
    logic [RAD_BITS-1:0]                rad_act;
    logic                               in_beat, on_grid, stamp_ok, resp_load;
    logic                               walk_start, cfg_we;
    logic signed [dsg_pkg::AMP_W:0]     amp_ext;
    logic [dsg_pkg::AMP_W:0]            mag;
    logic                               pol_ok, min_ok, max_ok;
    logic [AW-1:0]                      walk_addr;
    dsg_pkg::walk_status_t              walk_status;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= dsg_pkg::RADIUS_W'(1);
            width_reg    <= GW'(128);
            height_reg   <= GW'(128);
            polarity_reg <= 2'd0;
            min_mag_reg  <= '1;
            max_mag_reg  <= '1;
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                dsg_pkg::REG_RADIUS:   radius_reg   <= pwdata[dsg_pkg::RADIUS_W-1:0];
                dsg_pkg::REG_WIDTH:    width_reg    <= pwdata[GW-1:0];
                dsg_pkg::REG_HEIGHT:   height_reg   <= pwdata[GW-1:0];
                dsg_pkg::REG_POLARITY: polarity_reg <= pwdata[1:0];
                dsg_pkg::REG_MIN_MAG:  min_mag_reg  <= pwdata[dsg_pkg::AMP_W-1:0];
                dsg_pkg::REG_MAX_MAG:  max_mag_reg  <= pwdata[dsg_pkg::AMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            dsg_pkg::REG_RADIUS:   prdata = dsg_pkg::APB_DW'(radius_reg);
            dsg_pkg::REG_WIDTH:    prdata = dsg_pkg::APB_DW'(width_reg);
            dsg_pkg::REG_HEIGHT:   prdata = dsg_pkg::APB_DW'(height_reg);
            dsg_pkg::REG_POLARITY: prdata = dsg_pkg::APB_DW'(polarity_reg);
            dsg_pkg::REG_MIN_MAG:  prdata = dsg_pkg::APB_DW'($signed(min_mag_reg));
            dsg_pkg::REG_MAX_MAG:  prdata = dsg_pkg::APB_DW'($signed(max_mag_reg));
            default:               prdata = '0;
        endcase
    end

    // active geometry and strike filter
    assign w_act   = (width_reg > GW'(DIM_CAP)) ? GW'(DIM_CAP) : width_reg;
    assign h_act   = (height_reg > GW'(DIM_CAP)) ? GW'(DIM_CAP) : height_reg;
    assign rad_act = (radius_reg > MAX_RADIUS) ? RAD_BITS'(MAX_RADIUS) : RAD_BITS'(radius_reg);

    assign on_grid = (GW'(s_col) < w_act) && (GW'(s_row) < h_act);

    assign amp_ext = (dsg_pkg::AMP_W + 1)'(s_amplitude);
    assign mag     = s_amplitude[dsg_pkg::AMP_W-1] ? $unsigned(-amp_ext) : $unsigned(amp_ext);
    assign pol_ok  = !((polarity_reg == dsg_pkg::POL_POSITIVE) && s_amplitude[dsg_pkg::AMP_W-1])
                  && !((polarity_reg == dsg_pkg::POL_NEGATIVE) && !s_amplitude[dsg_pkg::AMP_W-1]
                       && (s_amplitude != '0));
    assign min_ok  = min_mag_reg[dsg_pkg::AMP_W-1] || (mag >= {1'b0, min_mag_reg});
    assign max_ok  = max_mag_reg[dsg_pkg::AMP_W-1] || (mag <= {1'b0, max_mag_reg});
    assign stamp_ok = on_grid && pol_ok && min_ok && max_ok;

    assign in_beat = s_valid && s_ready;

    dsg_walk #(
        .MAX_DIM    (MAX_DIM),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (walk_start),
        .col     (s_col),
        .row     (s_row),
        .radius  (rad_act),
        .width   (w_act),
        .height  (h_act),
        .status  (walk_status),
        .addr    (walk_addr)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dsg_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == dsg_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dsg_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == '1) begin
                    state_next = dsg_pkg::ST_IDLE;
                end
            end
            dsg_pkg::ST_IDLE: begin
                if (in_beat) begin
                    case (s_func) inside
                        dsg_pkg::FUNC_STAMP: begin
                            if (stamp_ok) begin
                                state_next = dsg_pkg::ST_STAMP;
                            end
                        end
                        dsg_pkg::FUNC_READ, dsg_pkg::FUNC_READ_CLEAR: begin
                            state_next = dsg_pkg::ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            dsg_pkg::ST_STAMP: begin
                if (walk_status.last) begin
                    state_next = dsg_pkg::ST_DRAIN;
                end
            end
            dsg_pkg::ST_DRAIN: state_next = dsg_pkg::ST_IDLE;
            dsg_pkg::ST_READ:  state_next = dsg_pkg::ST_RESP;
            dsg_pkg::ST_RESP: begin
                if (resp_load) begin
                    state_next = dsg_pkg::ST_IDLE;
                end
            end
            default: state_next = dsg_pkg::ST_IDLE;
        endcase
    end

    assign rdata_inc = (rdata_reg == '1) ? rdata_reg : rdata_reg + 1'b1;

    always_comb begin
        s_ready    = 1'b0;
        walk_start = 1'b0;
        resp_load  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = pend_addr_reg;
        mem_wdata  = rdata_inc;
        mem_raddr  = walk_addr;
        unique case (state_reg)
            dsg_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            dsg_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                walk_start = s_valid && (s_func == dsg_pkg::FUNC_STAMP) && stamp_ok;
            end
            dsg_pkg::ST_STAMP, dsg_pkg::ST_DRAIN: begin
                mem_we = pend_valid_reg;
            end
            dsg_pkg::ST_READ: begin
                mem_raddr = {DIM_BITS'(row_reg), DIM_BITS'(col_reg)};
            end
            dsg_pkg::ST_RESP: begin
                resp_load = !m_valid_reg || m_ready;
                mem_raddr = {DIM_BITS'(row_reg), DIM_BITS'(col_reg)};
                mem_we    = resp_load && on_grid_reg
                         && (func_reg == dsg_pkg::FUNC_READ_CLEAR);
                mem_waddr = {DIM_BITS'(row_reg), DIM_BITS'(col_reg)};
                mem_wdata = '0;
            end
            default: ;
        endcase
    end

    // cell memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= cell_mem[mem_raddr];
    end

    // read-modify-write pipe and request capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= (state_reg == dsg_pkg::ST_STAMP) && walk_status.hit;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= walk_addr;
        if (in_beat) begin
            func_reg    <= s_func;
            col_reg     <= s_col;
            row_reg     <= s_row;
            on_grid_reg <= on_grid;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (resp_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (resp_load) begin
            m_count_reg <= on_grid_reg ? dsg_pkg::OUT_W'(rdata_reg) : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_count = m_count_reg;

`ifndef SYNTHESIS
    a_no_beat_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dsg_pkg::ST_CLEAR) |-> !m_valid_reg)
        else $error("result beat during clearing sweep");

    a_pend_in_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (state_reg == dsg_pkg::ST_STAMP || state_reg == dsg_pkg::ST_DRAIN))
        else $error("cell update outside stamp");

    a_hit_in_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_status.hit |-> (state_reg == dsg_pkg::ST_STAMP))
        else $error("walker active outside stamp");

    a_resp_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dsg_pkg::ST_RESP && m_valid_reg && !m_ready)
            |=> (state_reg == dsg_pkg::ST_RESP))
        else $error("pending count overwritten");
`endif

endmodule

// ----- sim/disk_stamp_strike_density_grid_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_stamp_strike_density_grid_unit_test
// Self-checking bench for the strike density grid.
// ----------------------------------------------------------------------------
// A short table of directed beats covers the grid corners, every func code,
// the polarity and magnitude filters, off-grid strikes and reads, and zero
// and oversized geometry. Random phases follow, each with its own register
// setting. Strikes cluster around a few hot spots so reads land on stamped
// cells. A local grid copy predicts each count the table does not give.
// Count beats are checked in order against the oldest pending count. The
// output idles in random bursts but in the last phase, the input in some.
// ----------------------------------------------------------------------------
module disk_stamp_strike_density_grid_unit_test;

    localparam int GRID_DIM     = dsg_pkg::MAX_DIM_DEFAULT;
    localparam int RADIUS_LIMIT = dsg_pkg::MAX_RADIUS_DEFAULT;
    localparam logic [15:0] COUNT_CEIL = 16'hFFFF;
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic [1:0] POL_BOTH   = 2'd0;
    localparam int STAMP_SETTLE = (2 * RADIUS_LIMIT + 1) * (2 * RADIUS_LIMIT + 1) + 40;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 56;
    localparam longint unsigned LIMIT_NS = 64'd20_000_000;

    typedef struct packed {
        logic        wr;
        logic [2:0]  reg_idx;
        logic [15:0] reg_val;
        logic [1:0]  func;
        logic [6:0]  col;
        logic [6:0]  row;
        logic [15:0] amp;
        logic        typed;
        logic [15:0] cnt;
    } probe_row_t;

    localparam int PROBE_ROWS = 26;
    localparam probe_row_t PROBE_TABLE [0:PROBE_ROWS-1] = '{
        '{1'b0, dsg_pkg::REG_RADIUS,   16'd0,
          dsg_pkg::FUNC_READ,       7'd0,   7'd0,   16'd0,     1'b1, 16'd0},
        '{1'b0, dsg_pkg::REG_RADIUS,   16'd0,
          dsg_pkg::FUNC_STAMP,      7'd127, 7'd127, 16'h7FFF,  1'b0, 16'd0},
        '{1'b0, dsg_pkg::REG_RADIUS,   16'd0,
          dsg_pkg::FUNC_READ,       7'd127, 7'd127, 16'd0,     1'b1, 16'd1},
        '{1'b0, dsg_pkg::REG_RADIUS,   16'd0,
          dsg_pkg::FUNC_READ_CLEAR, 7'd126, 7'd127, 16'd0,     1'b1, 16'd1},
        '{1'b0, dsg_pkg::REG_RADIUS,   16'd0,
          dsg_pkg::FUNC_STAMP,      7'd0,   7'd0,   16'h8000,  1'b0, 16'd0},
        '{1'b0, dsg_pkg::REG_RADIUS,   16'd0,
          dsg_pkg::FUNC_READ,       7'd0,   7'd1,   16'd0,     1'b1, 16'd1},
        '{1'b0, dsg_pkg::REG_RADIUS,   16'd0,
          FUNC_SPARE,               7'd5,   7'd5,   16'd0,     1'b0, 16'd0},
        '{1'b1, dsg_pkg::REG_RADIUS,   16'd15,
          dsg_pkg::FUNC_STAMP,      7'd64,  7'd64,  16'd0,     1'b0, 16'd0},
        '{1'b0, dsg_pkg::REG_RADIUS,   16'd0,
          dsg_pkg::FUNC_READ,       7'd64,  7'd79,  16'd0,     1'b1, 16'd1},
        '{1'b1, dsg_pkg::REG_RADIUS,   16'd0,
          dsg_pkg::FUNC_STAMP,      7'd64,  7'd64,  16'd1,     1'b0, 16'd0},
        '{1'b0, dsg_pkg::REG_RADIUS,   16'd0,
          dsg_pkg::FUNC_READ_CLEAR, 7'd64,  7'd64,  16'd0,     1'b1, 16'd2},
        '{1'b1, dsg_pkg::REG_POLARITY, 16'd1,
          dsg_pkg::FUNC_STAMP,      7'd10,  7'd10,  16'hFFFB,  1'b0, 16'd0},
        '{1'b1, dsg_pkg::REG_POLARITY, 16'd2,
          dsg_pkg::FUNC_STAMP,      7'd10,  7'd10,  16'd5,     1'b0, 16'd0},
        '{1'b0, dsg_pkg::REG_RADIUS,   16'd0,
          dsg_pkg::FUNC_STAMP,      7'd10,  7'd10,  16'd0,     1'b0, 16'd0},
        '{1'b1, dsg_pkg::REG_POLARITY, 16'd3,
          dsg_pkg::FUNC_STAMP,      7'd10,  7'd10,  16'd7,     1'b0, 16'd0},
        '{1'b1, dsg_pkg::REG_MIN_MAG,  16'h7FFF,
          dsg_pkg::FUNC_STAMP,      7'd10,  7'd10,  16'h8000,  1'b0, 16'd0},
        '{1'b1, dsg_pkg::REG_MAX_MAG,  16'h7FFF,
          dsg_pkg::FUNC_STAMP,      7'd10,  7'd10,  16'h8000,  1'b0, 16'd0},
        '{1'b0, dsg_pkg::REG_RADIUS,   16'd0,
          dsg_pkg::FUNC_STAMP,      7'd10,  7'd10,  16'h7FFF,  1'b0, 16'd0},
        '{1'b0, dsg_pkg::REG_RADIUS,   16'd0,
          dsg_pkg::FUNC_READ,       7'd10,  7'd10,  16'd0,     1'b0, 16'd0},
        '{1'b1, dsg_pkg::REG_WIDTH,    16'd8,
          dsg_pkg::FUNC_STAMP,      7'd8,   7'd3,   16'd9,     1'b0, 16'd0},
        '{1'b0, dsg_pkg::REG_RADIUS,   16'd0,
          dsg_pkg::FUNC_READ,       7'd8,   7'd3,   16'd0,     1'b1, 16'd0},
        '{1'b1, dsg_pkg::REG_HEIGHT,   16'd4,
          dsg_pkg::FUNC_READ_CLEAR, 7'd2,   7'd4,   16'd0,     1'b1, 16'd0},
        '{1'b1, dsg_pkg::REG_WIDTH,    16'd0,
          dsg_pkg::FUNC_READ,       7'd0,   7'd0,   16'd0,     1'b1, 16'd0},
        '{1'b0, dsg_pkg::REG_RADIUS,   16'd0,
          dsg_pkg::FUNC_STAMP,      7'd0,   7'd0,   16'd3,     1'b0, 16'd0},
        '{1'b1, dsg_pkg::REG_WIDTH,    16'd200,
          dsg_pkg::FUNC_READ,       7'd0,   7'd0,   16'd0,     1'b0, 16'd0},
        '{1'b1, dsg_pkg::REG_HEIGHT,   16'd255,
          dsg_pkg::FUNC_READ_CLEAR, 7'd127, 7'd127, 16'd0,     1'b0, 16'd0}
    };

    logic                               aclk;
    logic                               aresetn = 1'b0;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [dsg_pkg::APB_AW-1:0]         paddr = '0;
    logic [dsg_pkg::APB_DW-1:0]         pwdata = '0;
    logic [dsg_pkg::APB_DW-1:0]         prdata;
    logic                               pready;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic [1:0]                         s_func = dsg_pkg::FUNC_STAMP;
    logic [dsg_pkg::COORD_W-1:0]        s_col = '0;
    logic [dsg_pkg::COORD_W-1:0]        s_row = '0;
    logic signed [dsg_pkg::AMP_W-1:0]   s_amplitude = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [dsg_pkg::OUT_W-1:0]          m_count;

    // predictor state
    logic [15:0]        strike_tally [0:GRID_DIM*GRID_DIM-1];
    logic [3:0]         radius_cfg = 4'd1;
    logic [7:0]         width_cfg = 8'd128;
    logic [7:0]         height_cfg = 8'd128;
    logic [1:0]         polarity_cfg = POL_BOTH;
    logic signed [15:0] min_mag_cfg = -16'sd1;
    logic signed [15:0] max_mag_cfg = -16'sd1;

    logic [15:0] pending_counts [$];
    bit          calm = 1'b0;
    int          mismatches = 0;
    int          counts_checked = 0;
    int          stamps_sent = 0;
    int          reads_sent = 0;
    int          settings_used = 0;

    disk_stamp_strike_density_grid_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_col       (s_col),
        .s_row       (s_row),
        .s_amplitude (s_amplitude),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_count     (m_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout with %0d counts still pending", pending_counts.size());
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit strike_passes(input logic signed [15:0] amp);
        int amp_i;
        int mag;
        amp_i = amp;
        mag = (amp_i < 0) ? -amp_i : amp_i;
        if (polarity_cfg == dsg_pkg::POL_POSITIVE && amp_i < 0)
            return 1'b0;
        if (polarity_cfg == dsg_pkg::POL_NEGATIVE && amp_i > 0)
            return 1'b0;
        if (min_mag_cfg >= 0 && mag < int'(min_mag_cfg))
            return 1'b0;
        if (max_mag_cfg >= 0 && mag > int'(max_mag_cfg))
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic advance_grid(input logic [1:0] f, input logic [6:0] c, input logic [6:0] r,
                                input logic signed [15:0] amp,
                                output bit has_count, output logic [15:0] cnt);
        int w;
        int h;
        int rad;
        int x;
        int y;
        int idx;
        w = (int'(width_cfg) > GRID_DIM) ? GRID_DIM : int'(width_cfg);
        h = (int'(height_cfg) > GRID_DIM) ? GRID_DIM : int'(height_cfg);
        rad = (int'(radius_cfg) > RADIUS_LIMIT) ? RADIUS_LIMIT : int'(radius_cfg);
        has_count = 1'b0;
        cnt = 16'd0;
        if (f == dsg_pkg::FUNC_STAMP) begin
            if (int'(c) < w && int'(r) < h && strike_passes(amp)) begin
                for (int dy = -rad; dy <= rad; dy++) begin
                    for (int dx = -rad; dx <= rad; dx++) begin
                        x = int'(c) + dx;
                        y = int'(r) + dy;
                        if (dx * dx + dy * dy <= rad * rad && x >= 0 && x < w
                                && y >= 0 && y < h) begin
                            idx = y * GRID_DIM + x;
                            if (strike_tally[idx] < COUNT_CEIL)
                                strike_tally[idx] = strike_tally[idx] + 16'd1;
                        end
                    end
                end
            end
        end else if (f == dsg_pkg::FUNC_READ || f == dsg_pkg::FUNC_READ_CLEAR) begin
            has_count = 1'b1;
            if (int'(c) < w && int'(r) < h) begin
                idx = int'(r) * GRID_DIM + int'(c);
                cnt = strike_tally[idx];
                if (f == dsg_pkg::FUNC_READ_CLEAR)
                    strike_tally[idx] = 16'd0;
            end
        end
    endtask

    // entered just after a rising edge
    task automatic send_beat(input logic [1:0] f, input logic [6:0] c, input logic [6:0] r,
                             input logic signed [15:0] amp,
                             input bit typed, input logic [15:0] typed_cnt);
        bit has_count;
        logic [15:0] cnt;
        s_valid <= 1'b1;
        s_func <= f;
        s_col <= c;
        s_row <= r;
        s_amplitude <= amp;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        advance_grid(f, c, r, amp, has_count, cnt);
        if (has_count) begin
            pending_counts = {pending_counts, (typed ? typed_cnt : cnt)};
            reads_sent++;
        end else if (f == dsg_pkg::FUNC_STAMP) begin
            stamps_sent++;
        end
    endtask

    task automatic idle_gap(input int pct);
        if (!calm && int'($urandom_range(0, 99)) < pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    // wait for every count, then let a stamp still walking run out
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge aclk);
        repeat (STAMP_SETTLE) @(posedge aclk);
    endtask

    task automatic program_reg(input logic [2:0] idx, input logic [15:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (!pready);
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            dsg_pkg::REG_RADIUS:   radius_cfg = val[3:0];
            dsg_pkg::REG_WIDTH:    width_cfg = val[7:0];
            dsg_pkg::REG_HEIGHT:   height_cfg = val[7:0];
            dsg_pkg::REG_POLARITY: polarity_cfg = val[1:0];
            dsg_pkg::REG_MIN_MAG:  min_mag_cfg = val;
            dsg_pkg::REG_MAX_MAG:  max_mag_cfg = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // count beats are stable from edge to edge, so look mid-cycle
    always @(negedge aclk) begin : count_check
        logic [15:0] head;
        if (aresetn && m_valid && m_ready) begin
            counts_checked++;
            if (pending_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: count beat %0d with nothing pending", $time, m_count);
            end else begin
                head = pending_counts.pop_front();
                if (m_count !== head) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: count mismatch, expected %0d got %0d",
                                 $time, head, m_count);
                end
            end
        end
    end

    initial begin
        @(posedge aclk);
        forever begin
            if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int hot_col [0:3];
        int hot_row [0:3];
        int w_eff;
        int h_eff;
        int rad_eff;
        int span;
        int k;
        int cc;
        int rr;
        int lo;
        int hi;
        int mag;
        int pick;
        int gap_pct;
        int issued;
        logic [1:0] f;
        logic signed [15:0] amp;
        logic [15:0] min_val;
        logic [15:0] max_val;

        for (int i = 0; i < GRID_DIM * GRID_DIM; i++)
            strike_tally[i] = 16'd0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < PROBE_ROWS; i++) begin
            if (PROBE_TABLE[i].wr) begin
                settle();
                program_reg(PROBE_TABLE[i].reg_idx, PROBE_TABLE[i].reg_val);
            end
            send_beat(PROBE_TABLE[i].func, PROBE_TABLE[i].col, PROBE_TABLE[i].row,
                      PROBE_TABLE[i].amp, PROBE_TABLE[i].typed, PROBE_TABLE[i].cnt);
            idle_gap(25);
        end

        // random phases
        for (int phase_no = 0; phase_no < PHASES; phase_no++) begin
            settle();
            calm = (phase_no == PHASES - 1);
            rad_eff = (phase_no == 0) ? 0 : (phase_no == 4) ? 15
                    : int'($urandom_range(1, 6));
            case ($urandom_range(0, 3))
                0: min_val = 16'hFFFF;
                1: min_val = 16'($urandom_range(0, 3000));
                2: min_val = 16'h8000;
                default: min_val = 16'd0;
            endcase
            if (phase_no == 5)
                min_val = 16'h7FFF;
            case ($urandom_range(0, 3))
                0: max_val = 16'hFFFF;
                1: max_val = 16'($urandom_range(3000, 32767));
                2: max_val = 16'h7FFF;
                default: max_val = 16'($urandom_range(0, 65535));
            endcase
            program_reg(dsg_pkg::REG_RADIUS, 16'(rad_eff));
            program_reg(dsg_pkg::REG_WIDTH, (phase_no == 1) ? 16'd1 : (phase_no == 2) ? 16'd255
                        : (phase_no == 6) ? 16'd128 : 16'($urandom_range(1, 255)));
            program_reg(dsg_pkg::REG_HEIGHT, (phase_no == 3) ? 16'd1 : (phase_no == 2) ? 16'd200
                        : (phase_no == 6) ? 16'd128 : 16'($urandom_range(1, 255)));
            program_reg(dsg_pkg::REG_POLARITY, 16'($urandom_range(0, 3)));
            program_reg(dsg_pkg::REG_MIN_MAG, min_val);
            program_reg(dsg_pkg::REG_MAX_MAG, max_val);
            settings_used++;

            w_eff = (int'(width_cfg) > GRID_DIM) ? GRID_DIM : int'(width_cfg);
            h_eff = (int'(height_cfg) > GRID_DIM) ? GRID_DIM : int'(height_cfg);
            span = rad_eff + 1;
            for (int j = 0; j < 4; j++) begin
                hot_col[j] = int'($urandom_range(0, w_eff - 1));
                hot_row[j] = int'($urandom_range(0, h_eff - 1));
            end
            gap_pct = (phase_no % 3 == 0) ? 0 : (phase_no % 3 == 1) ? 15 : 40;

            issued = 0;
            while (issued < PHASE_ITEMS) begin
                pick = int'($urandom_range(0, 99));
                k = int'($urandom_range(0, 3));
                cc = hot_col[k] + int'($urandom_range(0, 2 * span)) - span;
                rr = hot_row[k] + int'($urandom_range(0, 2 * span)) - span;
                cc = (cc < 0) ? 0 : (cc > 127) ? 127 : cc;
                rr = (rr < 0) ? 0 : (rr > 127) ? 127 : rr;
                amp = 16'($urandom_range(0, 65535));
                if (pick < 45) begin
                    f = dsg_pkg::FUNC_STAMP;
                    lo = (min_mag_cfg >= 0) ? int'(min_mag_cfg) : 0;
                    hi = (max_mag_cfg >= 0) ? int'(max_mag_cfg) : 32768;
                    if (polarity_cfg == dsg_pkg::POL_POSITIVE && hi > 32767)
                        hi = 32767;
                    if (lo <= hi && $urandom_range(0, 9) < 7) begin
                        mag = int'($urandom_range(lo, hi));
                        if (polarity_cfg == dsg_pkg::POL_NEGATIVE
                                || (polarity_cfg != dsg_pkg::POL_POSITIVE
                                    && $urandom_range(0, 1)))
                            amp = 16'(-mag);
                        else
                            amp = 16'((mag > 32767) ? 32767 : mag);
                    end
                    if ($urandom_range(0, 19) == 0)
                        amp = 16'sd0;
                end else if (pick < 80) begin
                    f = ($urandom_range(0, 3) == 0) ? dsg_pkg::FUNC_READ_CLEAR
                                                    : dsg_pkg::FUNC_READ;
                end else if (pick < 95) begin
                    f = 2'($urandom_range(0, 2));
                    cc = int'($urandom_range(0, 127));
                    rr = int'($urandom_range(0, 127));
                end else begin
                    f = FUNC_SPARE;
                    cc = int'($urandom_range(0, 127));
                    rr = int'($urandom_range(0, 127));
                end
                send_beat(f, 7'(cc), 7'(rr), amp, 1'b0, 16'd0);
                if (f != FUNC_SPARE)
                    issued++;
                idle_gap(gap_pct);
            end
        end

        s_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge aclk);
        repeat (STAMP_SETTLE) @(posedge aclk);

        $display("%0d strikes and %0d reads sent over %0d random register settings",
                 stamps_sent, reads_sent, settings_used);
        $display("%0d count beats checked, %0d mismatches", counts_checked, mismatches);
        if (mismatches == 0 && pending_counts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
